// ===== sv/partially_mapped_crossover_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the partially mapped crossover block
// Shared wrappers for clocked assertions that are disabled during reset.
// ---------------------------------------------------------------------------
`ifndef PARTIALLY_MAPPED_CROSSOVER_DEFINES_SVH
`define PARTIALLY_MAPPED_CROSSOVER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PMX_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PMX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/pmx_pkg.sv =====
// ---------------------------------------------------------------------------
// pmx_pkg
// Types, constants and state encodings shared by the crossover modules.
// ---------------------------------------------------------------------------
package pmx_pkg;

  localparam int PMX_MAX_JOBS    = 64;
  localparam int PMX_QUEUE_DEPTH = 2;
  localparam int JOB_W           = 7;
  localparam int POS_W           = 7;
  localparam int DRAW_W          = 31;
  localparam int JOB_SPAN        = 2 ** JOB_W;

  typedef logic [JOB_W-1:0] job_t;
  typedef logic [POS_W-1:0] pos_t;

  localparam job_t JOB_COUNT_RESET = job_t'(64);

  typedef struct packed {
    job_t              parent_a_job;
    job_t              parent_b_job;
    logic [DRAW_W-1:0] upper_draw;
    logic [DRAW_W-1:0] lower_draw;
  } pmx_in_t;

  typedef struct packed {
    job_t child_job;
    logic child_last;
  } pmx_out_t;

  typedef struct packed {
    logic we;
    logic bank;
    pos_t pos;
    job_t a_job;
    job_t b_job;
  } pmx_wr_t;

  typedef struct packed {
    logic bank;
    pos_t n;
    pos_t upper;
    pos_t lower;
    pos_t free_places;
  } pmx_desc_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } pmx_done_t;

  typedef enum logic [1:0] {
    F_LOAD,
    F_UPPER,
    F_LOWER,
    F_PUSH
  } front_state_t;

  typedef enum logic [4:0] {
    B_IDLE,
    B_BUILD_RD,
    B_BUILD_WR,
    B_SEG_RD,
    B_SEG_WR,
    B_MAP_RD,
    B_MAP_CHK,
    B_MAP_IDX,
    B_MAP_WALK,
    B_USED_RD,
    B_USED_CHK,
    B_FILL_RD,
    B_FILL_CHK,
    B_SCAN_RD,
    B_SCAN_CHK,
    B_EMIT_RD,
    B_EMIT_OUT
  } back_state_t;

endpackage

// ===== sv/pmx_front.sv =====
// ---------------------------------------------------------------------------
// pmx_front
// Loads parent positions into the current bank and derives the cut points.
// ---------------------------------------------------------------------------
module pmx_front
  import pmx_pkg::*;
#(
  parameter int MAX_JOBS = PMX_MAX_JOBS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  pmx_in_t   in_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  job_t      cfg_data,
  output pmx_wr_t   wr,
  output logic      push,
  output pmx_desc_t desc,
  input  logic      full,
  input  pmx_done_t done
);

  localparam pos_t MAX_POS = pos_t'(MAX_JOBS);
  localparam pos_t MIN_POS = pos_t'(2);
  localparam int   BIT_W   = $clog2(DRAW_W);
  localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(DRAW_W - 1);

  front_state_t      state_r, state_nxt;
  job_t              job_count_r;
  pos_t              load_pos_r;
  logic              bank_r;
  logic [1:0]        bank_busy_r, bank_busy_nxt;
  logic [DRAW_W-1:0] dividend_r;
  logic [DRAW_W-1:0] lower_draw_r;
  pos_t              rem_r;
  pos_t              divisor_r;
  logic [BIT_W-1:0]  bit_cnt_r;
  pos_t              n_r;
  pos_t              upper_r;
  pos_t              lower_r;
  pos_t              free_r;

  pos_t             n_eff;
  pos_t             next_pos;
  logic             is_final;
  logic             accept;
  logic [POS_W:0]   trial;
  logic [POS_W:0]   rem_wide;
  pos_t             rem_step;
  pos_t             rem_plus;
  pos_t             upper_fin;
  pos_t             lower_fin;
  pos_t             free_fin;

  always_comb begin
    if (job_count_r < MIN_POS) begin
      n_eff = MIN_POS;
    end else if (job_count_r > MAX_POS) begin
      n_eff = MAX_POS;
    end else begin
      n_eff = job_count_r;
    end
    next_pos = (load_pos_r >= MAX_POS) ? MAX_POS : load_pos_r + pos_t'(1);
    is_final = (next_pos >= n_eff);
    accept   = start && !busy;
  end

  // One bit of restoring remainder per cycle.
  always_comb begin
    trial = {rem_r, dividend_r[DRAW_W-1]};
    if (trial >= {1'b0, divisor_r}) begin
      rem_wide = trial - {1'b0, divisor_r};
    end else begin
      rem_wide = trial;
    end
    rem_step  = rem_wide[POS_W-1:0];
    rem_plus  = rem_step + pos_t'(1);
    upper_fin = upper_r;
    lower_fin = rem_plus;
    if (rem_plus == upper_r) begin
      if (upper_r < n_r) begin
        upper_fin = upper_r + pos_t'(1);
      end else begin
        lower_fin = rem_plus - pos_t'(1);
      end
    end
    free_fin = lower_fin + (n_r - upper_fin);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_LOAD: begin
        if (accept && is_final) begin
          state_nxt = F_UPPER;
        end
      end
      F_UPPER: begin
        if (bit_cnt_r == '0) begin
          state_nxt = F_LOWER;
        end
      end
      F_LOWER: begin
        if (bit_cnt_r == '0) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!full) begin
          state_nxt = F_LOAD;
        end
      end
    endcase
  end

  always_comb begin
    busy      = (state_r != F_LOAD) || bank_busy_r[bank_r] || full;
    push      = (state_r == F_PUSH) && !full;
    cfg_ready = 1'b1;
    wr        = '{we: accept, bank: bank_r, pos: next_pos,
                  a_job: in_data.parent_a_job, b_job: in_data.parent_b_job};
    desc      = '{bank: bank_r, n: n_r, upper: upper_r, lower: lower_r,
                  free_places: free_r};
    bank_busy_nxt = bank_busy_r;
    if (push) begin
      bank_busy_nxt[bank_r] = 1'b1;
    end
    if (done.valid) begin
      bank_busy_nxt[done.bank] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= F_LOAD;
      job_count_r <= JOB_COUNT_RESET;
      load_pos_r  <= '0;
      bank_r      <= 1'b0;
      bank_busy_r <= '0;
    end else begin
      state_r     <= state_nxt;
      bank_busy_r <= bank_busy_nxt;
      if (cfg_valid && cfg_ready) begin
        job_count_r <= cfg_data;
      end
      if (accept) begin
        load_pos_r <= is_final ? '0 : next_pos;
      end
      if (push) begin
        bank_r <= ~bank_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      F_LOAD: begin
        if (accept && is_final) begin
          dividend_r   <= in_data.upper_draw;
          lower_draw_r <= in_data.lower_draw;
          rem_r        <= '0;
          bit_cnt_r    <= LAST_BIT;
          divisor_r    <= n_eff;
          n_r          <= n_eff;
        end
      end
      F_UPPER: begin
        if (bit_cnt_r == '0) begin
          upper_r    <= rem_plus;
          divisor_r  <= rem_plus;
          dividend_r <= lower_draw_r;
          rem_r      <= '0;
          bit_cnt_r  <= LAST_BIT;
        end else begin
          dividend_r <= dividend_r << 1;
          rem_r      <= rem_step;
          bit_cnt_r  <= bit_cnt_r - BIT_W'(1);
        end
      end
      F_LOWER: begin
        dividend_r <= dividend_r << 1;
        rem_r      <= rem_step;
        bit_cnt_r  <= bit_cnt_r - BIT_W'(1);
        if (bit_cnt_r == '0) begin
          upper_r <= upper_fin;
          lower_r <= lower_fin;
          free_r  <= free_fin;
        end
      end
      F_PUSH: begin
      end
    endcase
  end

endmodule

// ===== sv/pmx_fifo.sv =====
// ---------------------------------------------------------------------------
// pmx_fifo
// Short queue of crossover run requests between the front and the back.
// ---------------------------------------------------------------------------
module pmx_fifo
  import pmx_pkg::*;
#(
  parameter int DEPTH = PMX_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  pmx_desc_t push_data,
  input  logic      pop,
  output pmx_desc_t pop_data,
  output logic      full,
  output logic      empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  pmx_desc_t        entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  always_comb begin
    full     = (count_r == CNT_W'(DEPTH));
    empty    = (count_r == '0);
    pop_data = entry_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== sv/pmx_back.sv =====
// ---------------------------------------------------------------------------
// pmx_back
// Holds the parent banks and runs one crossover request step by step.
// ---------------------------------------------------------------------------
module pmx_back
  import pmx_pkg::*;
#(
  parameter int MAX_JOBS = PMX_MAX_JOBS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  pmx_wr_t   wr,
  input  pmx_desc_t desc_in,
  input  logic      empty,
  output logic      pop,
  output logic      out_valid,
  output pmx_out_t  out_data,
  output pmx_done_t done
);

  localparam int IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;

  function automatic logic [IDX_W-1:0] pos_idx(input pos_t p);
    pos_t q;
    q = p - pos_t'(1);
    return q[IDX_W-1:0];
  endfunction

  job_t pa_mem    [2][MAX_JOBS];
  job_t pb_mem    [2][MAX_JOBS];
  pos_t pib_mem   [JOB_SPAN];
  job_t child_mem [MAX_JOBS];

  logic [JOB_SPAN-1:0] pib_vld_r;
  logic [JOB_SPAN-1:0] seg_r;
  logic [JOB_SPAN-1:0] used_r;
  logic [MAX_JOBS-1:0] child_vld_r;

  back_state_t state_r, state_nxt;
  pmx_desc_t   desc_r;
  pos_t        i_r;
  pos_t        k_r;
  pos_t        steps_r;
  job_t        bjob_r;
  job_t        pa_q_r;
  job_t        pb_q_r;
  pos_t        pib_q_r;
  logic        pib_vq_r;
  job_t        child_q_r;
  logic        child_vq_r;

  pos_t pa_rpos;
  pos_t pb_rpos;
  job_t pib_raddr;
  pos_t child_rpos;
  logic pib_we;
  job_t pib_waddr;
  pos_t pib_wdata;
  logic child_we;
  pos_t child_wpos;
  job_t child_wdata;
  logic seg_we;
  job_t seg_addr;
  logic used_we;
  job_t used_addr;
  logic run_clear;

  pos_t pib_val;
  job_t child_val;
  logic walk;
  logic i_at_n;
  logic i_at_up;
  logic need_fill;

  always_comb begin
    pib_val   = pib_vq_r ? pib_q_r : '0;
    child_val = child_vq_r ? child_q_r : '0;
    walk      = (pib_val >= desc_r.lower) && (pib_val <= desc_r.upper) &&
                (steps_r < desc_r.free_places);
    i_at_n    = (i_r == desc_r.n);
    i_at_up   = (i_r == desc_r.upper);
    need_fill = pib_vld_r[pb_q_r] && !used_r[pb_q_r];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:     if (!empty) state_nxt = B_BUILD_RD;
      B_BUILD_RD: state_nxt = B_BUILD_WR;
      B_BUILD_WR: state_nxt = i_at_n ? B_SEG_RD : B_BUILD_RD;
      B_SEG_RD:   state_nxt = B_SEG_WR;
      B_SEG_WR:   state_nxt = i_at_up ? B_MAP_RD : B_SEG_RD;
      B_MAP_RD:   state_nxt = B_MAP_CHK;
      B_MAP_CHK: begin
        if (seg_r[pb_q_r]) begin
          state_nxt = i_at_up ? B_USED_RD : B_MAP_RD;
        end else begin
          state_nxt = B_MAP_IDX;
        end
      end
      B_MAP_IDX: begin
        if (walk) begin
          state_nxt = B_MAP_WALK;
        end else begin
          state_nxt = i_at_up ? B_USED_RD : B_MAP_RD;
        end
      end
      B_MAP_WALK: state_nxt = B_MAP_IDX;
      B_USED_RD:  state_nxt = B_USED_CHK;
      B_USED_CHK: state_nxt = i_at_n ? B_FILL_RD : B_USED_RD;
      B_FILL_RD:  state_nxt = B_FILL_CHK;
      B_FILL_CHK: begin
        if (need_fill) begin
          state_nxt = B_SCAN_RD;
        end else begin
          state_nxt = i_at_n ? B_EMIT_RD : B_FILL_RD;
        end
      end
      B_SCAN_RD: begin
        if (k_r > desc_r.n) begin
          state_nxt = i_at_n ? B_EMIT_RD : B_FILL_RD;
        end else begin
          state_nxt = B_SCAN_CHK;
        end
      end
      B_SCAN_CHK: begin
        if (child_val != '0) begin
          state_nxt = B_SCAN_RD;
        end else begin
          state_nxt = i_at_n ? B_EMIT_RD : B_FILL_RD;
        end
      end
      B_EMIT_RD:  state_nxt = B_EMIT_OUT;
      B_EMIT_OUT: state_nxt = i_at_n ? B_IDLE : B_EMIT_RD;
      default:    state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    pa_rpos     = i_r;
    pb_rpos     = i_r;
    pib_raddr   = pa_q_r;
    child_rpos  = i_r;
    pib_we      = 1'b0;
    pib_waddr   = pb_q_r;
    pib_wdata   = i_r;
    child_we    = 1'b0;
    child_wpos  = i_r;
    child_wdata = pa_q_r;
    seg_we      = 1'b0;
    seg_addr    = pa_q_r;
    used_we     = 1'b0;
    used_addr   = child_val;
    pop         = 1'b0;
    run_clear   = 1'b0;
    out_valid   = 1'b0;
    out_data    = '{child_job: child_val, child_last: i_at_n};
    done        = '{valid: 1'b0, bank: desc_r.bank};
    unique case (state_r)
      B_IDLE: begin
        pop       = !empty;
        run_clear = !empty;
      end
      B_BUILD_WR: begin
        pib_we = 1'b1;
      end
      B_SEG_WR: begin
        child_we = 1'b1;
        seg_we   = 1'b1;
      end
      B_MAP_IDX: begin
        if (walk) begin
          pa_rpos = pib_val;
        end else if (pib_val != '0) begin
          child_we    = 1'b1;
          child_wpos  = pib_val;
          child_wdata = bjob_r;
        end
      end
      B_USED_CHK: begin
        used_we = (child_val != '0);
      end
      B_SCAN_RD: begin
        child_rpos = k_r;
      end
      B_SCAN_CHK: begin
        if (child_val == '0) begin
          child_we    = 1'b1;
          child_wpos  = k_r;
          child_wdata = bjob_r;
        end
      end
      B_EMIT_OUT: begin
        out_valid  = 1'b1;
        done.valid = i_at_n;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || run_clear) begin
      pib_vld_r   <= '0;
      seg_r       <= '0;
      used_r      <= '0;
      child_vld_r <= '0;
    end else begin
      if (pib_we) begin
        pib_vld_r[pib_waddr] <= 1'b1;
      end
      if (seg_we) begin
        seg_r[seg_addr] <= 1'b1;
      end
      if (used_we) begin
        used_r[used_addr] <= 1'b1;
      end
      if (child_we) begin
        child_vld_r[pos_idx(child_wpos)] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: begin
        if (!empty) begin
          desc_r <= desc_in;
          i_r    <= pos_t'(1);
        end
      end
      B_BUILD_WR: i_r <= i_at_n ? desc_r.lower : i_r + pos_t'(1);
      B_SEG_WR:   i_r <= i_at_up ? desc_r.lower : i_r + pos_t'(1);
      B_MAP_CHK: begin
        if (seg_r[pb_q_r]) begin
          i_r <= i_at_up ? pos_t'(1) : i_r + pos_t'(1);
        end else begin
          bjob_r  <= pb_q_r;
          steps_r <= '0;
        end
      end
      B_MAP_IDX: begin
        if (walk) begin
          steps_r <= steps_r + pos_t'(1);
        end else begin
          i_r <= i_at_up ? pos_t'(1) : i_r + pos_t'(1);
        end
      end
      B_USED_CHK: begin
        i_r <= i_at_n ? pos_t'(1) : i_r + pos_t'(1);
        k_r <= pos_t'(1);
      end
      B_FILL_CHK: begin
        bjob_r <= pb_q_r;
        if (!need_fill) begin
          i_r <= i_at_n ? pos_t'(1) : i_r + pos_t'(1);
        end
      end
      B_SCAN_RD: begin
        if (k_r > desc_r.n) begin
          i_r <= i_at_n ? pos_t'(1) : i_r + pos_t'(1);
        end
      end
      B_SCAN_CHK: begin
        if (child_val != '0) begin
          k_r <= k_r + pos_t'(1);
        end else begin
          i_r <= i_at_n ? pos_t'(1) : i_r + pos_t'(1);
        end
      end
      B_EMIT_OUT: i_r <= i_r + pos_t'(1);
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr.we) begin
      pa_mem[wr.bank][pos_idx(wr.pos)] <= wr.a_job;
      pb_mem[wr.bank][pos_idx(wr.pos)] <= wr.b_job;
    end
    pa_q_r <= pa_mem[desc_r.bank][pos_idx(pa_rpos)];
    pb_q_r <= pb_mem[desc_r.bank][pos_idx(pb_rpos)];
  end

  always_ff @(posedge clk) begin
    if (pib_we) begin
      pib_mem[pib_waddr] <= pib_wdata;
    end
    pib_q_r  <= pib_mem[pib_raddr];
    pib_vq_r <= pib_vld_r[pib_raddr];
  end

  always_ff @(posedge clk) begin
    if (child_we) begin
      child_mem[pos_idx(child_wpos)] <= child_wdata;
    end
    child_q_r  <= child_mem[pos_idx(child_rpos)];
    child_vq_r <= child_vld_r[pos_idx(child_rpos)];
  end

endmodule

// ===== sv/partially_mapped_crossover.sv =====
// ---------------------------------------------------------------------------
// partially_mapped_crossover
// Partially mapped crossover of two job permutations, one position per request.
// ---------------------------------------------------------------------------
// Each request loads one position of both parents; start is taken whenever
// busy is low. The request that fills the final position also supplies the
// two draws, and the front then runs two bit-serial remainders to find the
// cut points before handing the run to the back through a two-entry queue.
// The parents live in two banks, so the next pair can be loaded while the
// back works on the previous one; busy rises only while the cut points are
// computed and handed on, or while both banks are still in use. The back
// runs through single-port memory steps in this order: building the position
// index, copying the segment, walking the mapping chains, marking used jobs,
// filling the free places and emitting. Results come out as one-cycle strobes
// on out_valid, child_last marks the final one, and the receiver cannot stall
// them. No clearing pass follows reset.
// ---------------------------------------------------------------------------
`include "partially_mapped_crossover_defines.svh"

module partially_mapped_crossover
  import pmx_pkg::*;
#(
  parameter int MAX_JOBS    = PMX_MAX_JOBS,
  parameter int QUEUE_DEPTH = PMX_QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  pmx_in_t  in_data,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  job_t     cfg_data,
  output logic     out_valid,
  output pmx_out_t out_data
);

  pmx_wr_t   wr;
  pmx_desc_t push_desc;
  pmx_desc_t pop_desc;
  pmx_done_t done;
  logic      push;
  logic      pop;
  logic      full;
  logic      empty;

  pmx_front #(
    .MAX_JOBS (MAX_JOBS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .wr        (wr),
    .push      (push),
    .desc      (push_desc),
    .full      (full),
    .done      (done)
  );

  pmx_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_desc),
    .pop       (pop),
    .pop_data  (pop_desc),
    .full      (full),
    .empty     (empty)
  );

  pmx_back #(
    .MAX_JOBS (MAX_JOBS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (wr),
    .desc_in   (pop_desc),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .done      (done)
  );

  `PMX_ASSERT_SAME(a_push_not_full, push, !full, "run request pushed into a full queue")
  `PMX_ASSERT_SAME(a_pop_not_empty, pop, !empty, "run request popped from an empty queue")
  `PMX_ASSERT_SAME(a_last_ends_run, out_valid && out_data.child_last, done.valid, "last result without run completion")
  `PMX_ASSERT_NEXT(a_idle_after_run, done.valid, !out_valid, "result emitted right after run completion")

endmodule

// ===== verif/tb_partially_mapped_crossover.sv =====
// ---------------------------------------------------------------------------
// tb_partially_mapped_crossover
// Self-checking testbench for the partially mapped crossover block. Parent
// pairs are loaded one position per request, and every emitted child job is
// compared with a behavioral prediction of the crossover. Directed cases come
// first, then random runs of mostly valid permutations under varying counts
// and sender idling.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_partially_mapped_crossover;
  import pmx_pkg::*;

  localparam int WATCHDOG_LIMIT = 100000;
  localparam int SETTLE_CYCLES  = 100;
  localparam logic [DRAW_W-1:0] DRAW_MAX = '1;

  typedef enum int {
    RUN_VALID,
    RUN_BROKEN,
    RUN_NOISE
  } run_kind_t;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     start;
  logic     busy;
  pmx_in_t  in_data;
  logic     cfg_valid;
  logic     cfg_ready;
  job_t     cfg_data;
  logic     out_valid;
  pmx_out_t out_data;

  job_t       parent_a_mem [1:PMX_MAX_JOBS];
  job_t       parent_b_mem [1:PMX_MAX_JOBS];
  int         loaded_positions = 0;
  job_t       job_count_reg = JOB_COUNT_RESET;
  pmx_out_t   child_queue [$];
  int         mismatches = 0;
  int         items_sent = 0;
  int         sender_idle_pct = 0;
  int         idle_cycles = 0;

  partially_mapped_crossover uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  function automatic int effective_count();
    int n;
    n = int'(job_count_reg);
    if (n < 2) n = 2;
    if (n > PMX_MAX_JOBS) n = PMX_MAX_JOBS;
    return n;
  endfunction

  function automatic void predict_child(input int n, input logic [DRAW_W-1:0] up_draw,
                                        input logic [DRAW_W-1:0] lo_draw);
    int       pos_b [JOB_SPAN];
    bit       taken [JOB_SPAN];
    job_t     child [PMX_MAX_JOBS+1];
    int       up;
    int       lb;
    int       free_places;
    int       idx;
    int       steps;
    int       k;
    pmx_out_t res;
    for (int j = 0; j < JOB_SPAN; j++) begin
      pos_b[j] = 0;
      taken[j] = 1'b0;
    end
    for (int j = 0; j <= PMX_MAX_JOBS; j++) child[j] = '0;
    for (int i = 1; i <= n; i++) pos_b[parent_b_mem[i]] = i;

    up = int'(up_draw % n) + 1;
    lb = int'(lo_draw % up) + 1;
    if (lb == up) begin
      if (up < n) up++;
      else lb--;
    end
    free_places = lb + (n - up);

    for (int i = lb; i <= up; i++) begin
      child[i] = parent_a_mem[i];
      taken[parent_a_mem[i]] = 1'b1;
    end
    for (int i = lb; i <= up; i++) begin
      if (!taken[parent_b_mem[i]]) begin
        idx = pos_b[parent_a_mem[i]];
        steps = 0;
        while (lb <= idx && idx <= up && steps < free_places) begin
          idx = pos_b[parent_a_mem[idx]];
          steps++;
        end
        child[idx] = parent_b_mem[i];
      end
    end

    for (int i = 1; i <= n; i++) begin
      if (child[i] != '0) pos_b[child[i]] = 0;
    end
    k = 1;
    for (int i = 1; i <= n; i++) begin
      if (pos_b[parent_b_mem[i]] != 0) begin
        while (k <= n && child[k] != '0) k++;
        if (k <= n) child[k] = parent_b_mem[i];
      end
    end

    for (int i = 1; i <= n; i++) begin
      res.child_job  = child[i];
      res.child_last = (i == n);
      child_queue.push_back(res);
    end
  endfunction

  function automatic void shuffle_jobs(input int n, output job_t jobs [PMX_MAX_JOBS+1]);
    int   j;
    job_t tmp;
    for (int i = 1; i <= n; i++) jobs[i] = job_t'(i);
    for (int i = n; i > 1; i--) begin
      j = $urandom_range(i, 1);
      tmp = jobs[i];
      jobs[i] = jobs[j];
      jobs[j] = tmp;
    end
  endfunction

  function automatic logic [DRAW_W-1:0] random_draw();
    case ($urandom_range(9))
      0: return '0;
      1: return DRAW_MAX;
      default: return DRAW_W'($urandom);
    endcase
  endfunction

  function automatic job_t pick_count();
    int r;
    r = $urandom_range(99);
    if (r < 78) return job_t'($urandom_range(10, 2));
    if (r < 90) return job_t'($urandom_range(63, 11));
    if (r < 95) return job_t'(PMX_MAX_JOBS);
    if ($urandom_range(1)) return job_t'($urandom_range(1));
    return job_t'($urandom_range(127, 65));
  endfunction

  task automatic send_request(input pmx_in_t req);
    int n;
    int pos;
    in_data <= req;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    n = effective_count();
    pos = loaded_positions + 1;
    if (pos > PMX_MAX_JOBS) pos = PMX_MAX_JOBS;
    parent_a_mem[pos] = req.parent_a_job;
    parent_b_mem[pos] = req.parent_b_job;
    loaded_positions = pos;
    if (loaded_positions >= n) begin
      loaded_positions = 0;
      predict_child(n, req.upper_draw, req.lower_draw);
    end
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic wait_child_done();
    start <= 1'b0;
    while (child_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_job_count(input job_t value);
    wait_child_done();
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    job_count_reg = value;
  endtask

  // Sends the positions still missing from the current load. Negative forced
  // draws mean random draws; max_items of zero means run to the final position.
  task automatic send_run(input run_kind_t kind, input longint forced_upper,
                          input longint forced_lower, input int max_items);
    job_t    a_jobs [PMX_MAX_JOBS+1];
    job_t    b_jobs [PMX_MAX_JOBS+1];
    pmx_in_t req;
    int      n;
    int      pos;
    int      sent;
    int      p;
    n = effective_count();
    shuffle_jobs(n, a_jobs);
    shuffle_jobs(n, b_jobs);
    if (kind == RUN_BROKEN) begin
      repeat ($urandom_range(3, 1)) begin
        p = $urandom_range(n, 1);
        if ($urandom_range(1)) a_jobs[p] = job_t'($urandom_range(127));
        else b_jobs[p] = job_t'($urandom_range(127));
      end
    end else if (kind == RUN_NOISE) begin
      for (int i = 1; i <= n; i++) begin
        a_jobs[i] = job_t'($urandom_range(127));
        b_jobs[i] = job_t'($urandom_range(127));
      end
    end
    pos = loaded_positions + 1;
    sent = 0;
    do begin
      req.parent_a_job = (pos <= n) ? a_jobs[pos] : job_t'($urandom_range(127));
      req.parent_b_job = (pos <= n) ? b_jobs[pos] : job_t'($urandom_range(127));
      req.upper_draw   = random_draw();
      req.lower_draw   = random_draw();
      if (pos >= n && forced_upper >= 0) req.upper_draw = DRAW_W'(forced_upper);
      if (pos >= n && forced_lower >= 0) req.lower_draw = DRAW_W'(forced_lower);
      send_request(req);
      pos++;
      sent++;
    end while (pos <= n && (max_items == 0 || sent < max_items));
  endtask

  task automatic test_count_change_mid_load();
    send_run(RUN_VALID, -1, -1, 3);
    write_job_count(job_t'(3));
    send_run(RUN_VALID, -1, -1, 0);
  endtask

  task automatic test_count_clamp_low();
    write_job_count(job_t'(0));
    send_run(RUN_VALID, longint'(DRAW_MAX), longint'(DRAW_MAX), 0);
    write_job_count(job_t'(1));
    send_run(RUN_VALID, 0, 0, 0);
  endtask

  task automatic test_equal_cut_points();
    write_job_count(job_t'(4));
    send_run(RUN_VALID, 1, 1, 0);
    send_run(RUN_VALID, 3, 3, 0);
  endtask

  task automatic test_invalid_permutations();
    job_t    bad_a [5];
    job_t    bad_b [5];
    pmx_in_t req;
    bad_a = '{job_t'(0), job_t'(127), job_t'(3), job_t'(3), job_t'(1)};
    bad_b = '{job_t'(3), job_t'(1), job_t'(127), job_t'(64), job_t'(0)};
    write_job_count(job_t'(5));
    for (int i = 0; i < 5; i++) begin
      req.parent_a_job = bad_a[i];
      req.parent_b_job = bad_b[i];
      req.upper_draw   = (i == 4) ? DRAW_W'(3) : random_draw();
      req.lower_draw   = (i == 4) ? DRAW_W'(1) : random_draw();
      send_request(req);
    end
  endtask

  task automatic test_random_traffic(input int idle_pct, input int item_goal);
    int        first_item;
    int        r;
    run_kind_t kind;
    sender_idle_pct = idle_pct;
    first_item = items_sent;
    while (items_sent - first_item < item_goal) begin
      if (loaded_positions != 0 || $urandom_range(2) == 0) write_job_count(pick_count());
      r = $urandom_range(99);
      kind = (r < 75) ? RUN_VALID : (r < 90) ? RUN_BROKEN : RUN_NOISE;
      if ($urandom_range(19) == 0) begin
        send_run(kind, -1, -1, $urandom_range(effective_count() - 1, 1));
      end else begin
        send_run(kind, -1, -1, 0);
      end
    end
  endtask

  always @(posedge clk) begin : check_child
    pmx_out_t expected_res;
    if (rst_n && out_valid) begin
      if (child_queue.size() == 0) begin
        $display("%0t ns: unexpected child result, expected none, actual job %0d last %0b",
                 $time, out_data.child_job, out_data.child_last);
        mismatches++;
      end else begin
        expected_res = child_queue.pop_front();
        if (out_data.child_job !== expected_res.child_job) begin
          $display("%0t ns: child_job mismatch, expected %0d, actual %0d",
                   $time, expected_res.child_job, out_data.child_job);
          mismatches++;
        end
        if (out_data.child_last !== expected_res.child_last) begin
          $display("%0t ns: child_last mismatch, expected %0b, actual %0b",
                   $time, expected_res.child_last, out_data.child_last);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no request or result for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("partially_mapped_crossover regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    sender_idle_pct = 14;
    test_count_change_mid_load();
    test_count_clamp_low();
    test_equal_cut_points();
    test_invalid_permutations();

    test_random_traffic(14, 150);
    test_random_traffic(69, 150);
    test_random_traffic(0, 140);

    wait_child_done();
    if (mismatches == 0) begin
      $display("partially_mapped_crossover regression: pass");
    end else begin
      $display("partially_mapped_crossover regression: fail");
    end
    $finish;
  end

endmodule
